/* design/blr_pkg.sv */
`timescale 1ns / 1ps
// blr_pkg: types, widths and register codes of the 3x3 rgba blur
// no dependencies
package blr_pkg;

   localparam int PIX_W           = 8;
   localparam int VSUM_W          = PIX_W + 2;
   localparam int CFG_WIDTH_W     = 11;
   localparam int CFG_HEIGHT_W    = 13;
   localparam int CSR_DATA_W      = 13;
   localparam int CSR_INDEX_W     = 1;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_MAX_HEIGHT  = 4096;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = CFG_WIDTH_W'(1024);
   localparam logic [CFG_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = CFG_HEIGHT_W'(1024);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } blr_csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] alpha;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } blr_pixel_type;

   typedef struct packed {
      blr_pixel_type upper;
      blr_pixel_type middle;
      blr_pixel_type lower;
   } blr_column_type;

   typedef struct packed {
      logic [VSUM_W-1:0] alpha;
      logic [VSUM_W-1:0] blue;
      logic [VSUM_W-1:0] green;
      logic [VSUM_W-1:0] red;
   } blr_vsum_type;

   // border masking of the window, set means the neighbours there are zero
   typedef struct packed {
      logic row_top;
      logic row_bottom;
      logic col_left;
      logic col_right;
   } blr_mask_type;

endpackage

/* design/blr_channels.sv */
`timescale 1ns / 1ps
// blr channel interfaces: pixel request, blurred response and register write
// depends on blr_pkg
interface blr_req_if;
   import blr_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] in_red;
   logic [PIX_W-1:0] in_green;
   logic [PIX_W-1:0] in_blue;
   logic [PIX_W-1:0] in_alpha;
   logic             is_filler;
   modport source (output valid, in_red, in_green, in_blue, in_alpha, is_filler, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, in_alpha, is_filler, output ready);
endinterface

interface blr_rsp_if;
   import blr_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic [PIX_W-1:0] out_alpha;
   logic             frame_end;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   output ready);
endinterface

interface blr_csr_if;
   import blr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/blr_line_store.sv */
`timescale 1ns / 1ps
// blr_line_store: upper and middle line memories with registered reads
// depends on blr_pkg
module blr_line_store #(
   parameter int DEPTH = blr_pkg::DEF_MAX_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  blr_pkg::blr_pixel_type     pix,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   output blr_pkg::blr_pixel_type     up_out,
   output blr_pkg::blr_pixel_type     mid_out
);
   import blr_pkg::*;

   blr_pixel_type upper_mem [DEPTH];
   blr_pixel_type middle_mem [DEPTH];
   blr_pixel_type up_rd_ff;
   blr_pixel_type mid_rd_ff;
   blr_pixel_type fwd_data_ff;
   logic          fwd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_rd_ff           <= upper_mem[rd_addr];
         mid_rd_ff          <= middle_mem[rd_addr];
         middle_mem[rd_addr] <= pix;
         fwd_data_ff        <= mid_rd_ff;
      end
      // upper row takes the old middle entry one transaction later
      if (wr_en) begin
         upper_mem[wr_addr] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign up_out  = fwd_ff ? fwd_data_ff : up_rd_ff;
   assign mid_out = mid_rd_ff;

endmodule

/* design/blr_tap_cell.sv */
`timescale 1ns / 1ps
// blr_tap_cell: one window column, shifts left and gives its vertical 1-2-1 sums
// depends on blr_pkg
module blr_tap_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  blr_pkg::blr_column_type col_in,
   input  blr_pkg::blr_mask_type   mask,
   output blr_pkg::blr_column_type col_out,
   output blr_pkg::blr_vsum_type   vsum
);
   import blr_pkg::*;

   blr_column_type col_ff;

   function automatic logic [VSUM_W-1:0] vsum_ch(
      input logic [PIX_W-1:0] u,
      input logic [PIX_W-1:0] m,
      input logic [PIX_W-1:0] l,
      input logic             drop_u,
      input logic             drop_l
   );
      logic [VSUM_W-1:0] su;
      logic [VSUM_W-1:0] sl;
      su = drop_u ? '0 : VSUM_W'(u);
      sl = drop_l ? '0 : VSUM_W'(l);
      return su + (VSUM_W'(m) << 1) + sl;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   always_comb begin
      vsum.red   = vsum_ch(col_ff.upper.red, col_ff.middle.red, col_ff.lower.red,
                           mask.row_top, mask.row_bottom);
      vsum.green = vsum_ch(col_ff.upper.green, col_ff.middle.green, col_ff.lower.green,
                           mask.row_top, mask.row_bottom);
      vsum.blue  = vsum_ch(col_ff.upper.blue, col_ff.middle.blue, col_ff.lower.blue,
                           mask.row_top, mask.row_bottom);
      vsum.alpha = vsum_ch(col_ff.upper.alpha, col_ff.middle.alpha, col_ff.lower.alpha,
                           mask.row_top, mask.row_bottom);
   end

endmodule

/* design/blr_kernel.sv */
`timescale 1ns / 1ps
// blr_kernel: horizontal 1-2-1 combine of the column sums and divide by 16
// depends on blr_pkg
module blr_kernel (
   input  blr_pkg::blr_vsum_type  vsum_left,
   input  blr_pkg::blr_vsum_type  vsum_centre,
   input  blr_pkg::blr_vsum_type  vsum_right,
   input  blr_pkg::blr_mask_type  mask,
   output blr_pkg::blr_pixel_type result
);
   import blr_pkg::*;

   localparam int SUM_W = VSUM_W + 2;

   function automatic logic [PIX_W-1:0] hsum_ch(
      input logic [VSUM_W-1:0] l,
      input logic [VSUM_W-1:0] c,
      input logic [VSUM_W-1:0] r,
      input logic              drop_l,
      input logic              drop_r
   );
      logic [SUM_W-1:0] sum;
      sum = (drop_l ? '0 : SUM_W'(l)) + (SUM_W'(c) << 1) + (drop_r ? '0 : SUM_W'(r));
      return sum[SUM_W-1:4];
   endfunction

   always_comb begin
      result.red   = hsum_ch(vsum_left.red, vsum_centre.red, vsum_right.red,
                             mask.col_left, mask.col_right);
      result.green = hsum_ch(vsum_left.green, vsum_centre.green, vsum_right.green,
                             mask.col_left, mask.col_right);
      result.blue  = hsum_ch(vsum_left.blue, vsum_centre.blue, vsum_right.blue,
                             mask.col_left, mask.col_right);
      result.alpha = hsum_ch(vsum_left.alpha, vsum_centre.alpha, vsum_right.alpha,
                             mask.col_left, mask.col_right);
   end

endmodule

/* design/gaussian_blur_3x3_rgba.sv */
`timescale 1ns / 1ps
// gaussian_blur_3x3_rgba: streaming 3x3 gaussian blur of rgba pixels in raster order
// each result passes the s1 registers, window cells and response register; one transaction
// per cycle unless the response stalls, each line store doing one read and one write a cycle
// results trail the stream by image_width + 1 positions; fillers drain the last row
// reset: position, window and valid bits clear, width and height return to 1024;
// line stores are not cleared and need no clearing pass
module gaussian_blur_3x3_rgba #(
   parameter int MAX_WIDTH  = blr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = blr_pkg::DEF_MAX_HEIGHT
) (
   input  logic          clock,
   input  logic          reset,
   blr_req_if.sink       req_chan,
   blr_rsp_if.source     rsp_chan,
   blr_csr_if.sink       csr_chan
);
   import blr_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT + 2);

   logic [CFG_WIDTH_W-1:0]  width_cfg_ff;
   logic [CFG_HEIGHT_W-1:0] height_cfg_ff;
   logic [XW-1:0]           col_ff, col_in;
   logic [YW-1:0]           row_ff, row_in;

   logic [31:0]     w32, h32, x32, y32;
   logic            adv, accept;
   logic            have, last;
   blr_mask_type    mask;
   blr_pixel_type   pix;

   logic            s1_valid_ff, s1_have_ff, s1_last_ff;
   blr_mask_type    s1_mask_ff;
   blr_pixel_type   s1_pix_ff;
   logic [XW-1:0]   s1_x_ff;
   logic            s2_valid_ff, s2_last_ff;
   blr_mask_type    s2_mask_ff;
   logic            rsp_valid_ff, rsp_last_ff;
   blr_pixel_type   rsp_pix_ff;

   blr_pixel_type   up_out, mid_out;
   blr_column_type  new_col;
   blr_column_type  cell_in [3];
   blr_column_type  cell_out [3];
   blr_vsum_type    cell_vsum [3];
   blr_pixel_type   blur;
   logic            shift_en;

   // register port
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= RESET_IMAGE_WIDTH;
         height_cfg_ff <= RESET_IMAGE_HEIGHT;
      end else if (csr_chan.valid) begin
         case (blr_csr_index_type'(csr_chan.index))
            CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_chan.data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_chan.data[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // stream position and border flags
   assign adv    = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && adv;
   assign req_chan.ready = adv;

   always_comb begin
      if (width_cfg_ff == '0) begin
         w32 = 32'd1;
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         w32 = 32'(MAX_WIDTH);
      end else begin
         w32 = 32'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         h32 = 32'd1;
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         h32 = 32'(MAX_HEIGHT);
      end else begin
         h32 = 32'(height_cfg_ff);
      end
      x32 = (32'(col_ff) >= w32) ? 32'd0 : 32'(col_ff);
      y32 = (32'(row_ff) > h32 + 32'd1) ? 32'd0 : 32'(row_ff);

      if (x32 != 32'd0) begin
         have            = (y32 >= 32'd1) && (y32 <= h32);
         mask.row_top    = (y32 == 32'd1);
         mask.row_bottom = (y32 == h32);
         mask.col_left   = (x32 == 32'd1);
         mask.col_right  = 1'b0;
         last            = 1'b0;
      end else begin
         have            = (y32 >= 32'd2);
         mask.row_top    = (y32 == 32'd2);
         mask.row_bottom = (y32 == h32 + 32'd1);
         mask.col_left   = (w32 == 32'd1);
         mask.col_right  = 1'b1;
         last            = have && (y32 == h32 + 32'd1);
      end

      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (x32 + 32'd1 >= w32) begin
         col_in = '0;
         row_in = YW'(y32 + 32'd1);
      end else begin
         col_in = XW'(x32 + 32'd1);
         row_in = YW'(y32);
      end

      if (req_chan.is_filler) begin
         pix = '0;
      end else begin
         pix.red   = req_chan.in_red;
         pix.green = req_chan.in_green;
         pix.blue  = req_chan.in_blue;
         pix.alpha = req_chan.in_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores
   blr_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (XW'(x32)),
      .pix     (pix),
      .wr_en   (shift_en),
      .wr_addr (s1_x_ff),
      .up_out  (up_out),
      .mid_out (mid_out)
   );

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff && s1_have_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_have_ff <= have;
         s1_last_ff <= last;
         s1_mask_ff <= mask;
         s1_pix_ff  <= pix;
         s1_x_ff    <= XW'(x32);
      end
      if (adv) begin
         s2_last_ff  <= s1_last_ff;
         s2_mask_ff  <= s1_mask_ff;
         rsp_last_ff <= s2_last_ff;
         rsp_pix_ff  <= blur;
      end
   end

   // window: chain of column cells, newest column enters on the right
   assign shift_en       = adv && s1_valid_ff;
   assign new_col.upper  = up_out;
   assign new_col.middle = mid_out;
   assign new_col.lower  = s1_pix_ff;

   for (genvar i = 0; i < 3; i++) begin : g_cell
      if (i == 2) begin : g_feed
         assign cell_in[i] = new_col;
      end else begin : g_chain
         assign cell_in[i] = cell_out[i+1];
      end
      blr_tap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .col_in   (cell_in[i]),
         .mask     (s2_mask_ff),
         .col_out  (cell_out[i]),
         .vsum     (cell_vsum[i])
      );
   end

   blr_kernel u_kernel (
      .vsum_left   (cell_vsum[0]),
      .vsum_centre (cell_vsum[1]),
      .vsum_right  (cell_vsum[2]),
      .mask        (s2_mask_ff),
      .result      (blur)
   );

   // response
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_red   = rsp_pix_ff.red;
   assign rsp_chan.out_green = rsp_pix_ff.green;
   assign rsp_chan.out_blue  = rsp_pix_ff.blue;
   assign rsp_chan.out_alpha = rsp_pix_ff.alpha;
   assign rsp_chan.frame_end = rsp_last_ff;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench of gaussian_blur_3x3_rgba, predicts every blurred pixel
// and compares each response transaction field by field; depends on blr_pkg and the
// blr channel interfaces
module tb;
   import blr_pkg::*;

   localparam int MAX_W       = DEF_MAX_WIDTH;
   localparam int MAX_H       = DEF_MAX_HEIGHT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 120;

   typedef struct packed {
      blr_pixel_type colour;
      logic          frame_end;
   } blur_result_type;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   error_count = 0;
   int   checked_count = 0;
   int   pixels_sent = 0;
   logic steady;

   blr_req_if req_chan ();
   blr_rsp_if rsp_chan ();
   blr_csr_if csr_chan ();

   gaussian_blur_3x3_rgba DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // predictor state
   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   blr_pixel_type           upper_line [MAX_W];
   blr_pixel_type           middle_line [MAX_W];
   blr_pixel_type           window_taps [9];
   int unsigned             col_pos;
   int unsigned             row_pos;
   blur_result_type         pending_blurs [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   assign steady = (cycle_count % 1000) >= 600;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("error: %s", what);
      error_count++;
   endtask

   function automatic int unsigned clamped(input int unsigned value, input int unsigned ceiling);
      return (value == 0) ? 1 : ((value > ceiling) ? ceiling : value);
   endfunction

   function automatic blr_pixel_type any_pixel();
      return blr_pixel_type'($urandom);
   endfunction

   function automatic void predict_blur(input blr_pixel_type px_in, input logic filler);
      int unsigned     w, h, x, y, qx, qy, k, wt;
      int unsigned     sum_r, sum_g, sum_b, sum_a;
      blr_pixel_type   px, up, mid;
      bit              have, last, keep;
      blur_result_type result;
      w = clamped(width_reg, MAX_W);
      h = clamped(height_reg, MAX_H);
      x = col_pos;
      y = row_pos;
      if (x >= w) x = 0;
      if (y > h + 1) y = 0;
      px = filler ? blr_pixel_type'('0) : px_in;
      up = upper_line[x];
      mid = middle_line[x];
      upper_line[x] = mid;
      middle_line[x] = px;
      for (int r = 0; r < 3; r++) begin
         window_taps[r*3] = window_taps[r*3 + 1];
         window_taps[r*3 + 1] = window_taps[r*3 + 2];
      end
      window_taps[2] = up;
      window_taps[5] = mid;
      window_taps[8] = px;
      have = 1'b0;
      last = 1'b0;
      qx = 0;
      qy = 0;
      if (x >= 1) begin
         have = (y >= 1);
         qx = x - 1;
         qy = y - 1;
      end else begin
         have = (y >= 2);
         qx = w - 1;
         qy = y - 2;
      end
      if (have && qy >= h) have = 1'b0;
      if (have) begin
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         sum_a = 0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               // neighbours beyond the border are zero, no renormalisation
               keep = !((r == 0 && qy == 0) || (r == 2 && qy == h - 1) ||
                        (c == 0 && qx == 0) || (c == 2 && qx == w - 1));
               k = r*3 + c;
               wt = ((r == 1) ? 2 : 1) * ((c == 1) ? 2 : 1);
               if (keep) begin
                  sum_r += wt * window_taps[k].red;
                  sum_g += wt * window_taps[k].green;
                  sum_b += wt * window_taps[k].blue;
                  sum_a += wt * window_taps[k].alpha;
               end
            end
         end
         last = (qy == h - 1) && (qx == w - 1);
         result.colour.red   = 8'(sum_r >> 4);
         result.colour.green = 8'(sum_g >> 4);
         result.colour.blue  = 8'(sum_b >> 4);
         result.colour.alpha = 8'(sum_a >> 4);
         result.frame_end    = last;
         pending_blurs.push_back(result);
      end
      if (last) begin
         x = 0;
         y = 0;
      end else if (x + 1 >= w) begin
         x = 0;
         y = y + 1;
      end else begin
         x = x + 1;
      end
      col_pos = x;
      row_pos = y;
   endfunction

   task automatic send_pixel(input blr_pixel_type px, input logic filler);
      while (!steady && $urandom_range(99) < 12) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.in_red    <= px.red;
      req_chan.in_green  <= px.green;
      req_chan.in_blue   <= px.blue;
      req_chan.in_alpha  <= px.alpha;
      req_chan.is_filler <= filler;
      do @(posedge clock); while (!req_chan.ready);
      predict_blur(px, filler);
      pixels_sent++;
   endtask

   // feed drain items until the image is closed and the position is back at zero
   task automatic drain_image(input int unsigned pixel_percent);
      while (col_pos != 0 || row_pos != 0)
         send_pixel(any_pixel(), $urandom_range(99) >= pixel_percent);
   endtask

   task automatic send_image(input int unsigned filler_percent);
      int unsigned n;
      n = clamped(width_reg, MAX_W) * clamped(height_reg, MAX_H);
      repeat (n) send_pixel(any_pixel(), $urandom_range(99) < filler_percent);
   endtask

   task automatic configure(input bit keep_width, input logic [CSR_DATA_W-1:0] width_data,
                            input logic [CSR_DATA_W-1:0] height_data);
      req_chan.valid <= 1'b0;
      while (pending_blurs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!keep_width) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= CSR_IMAGE_WIDTH;
         csr_chan.data  <= width_data;
         do @(posedge clock); while (!csr_chan.ready);
         width_reg = width_data[CFG_WIDTH_W-1:0];
      end
      csr_chan.valid <= 1'b1;
      csr_chan.index <= CSR_IMAGE_HEIGHT;
      csr_chan.data  <= height_data;
      do @(posedge clock); while (!csr_chan.ready);
      height_reg = height_data[CFG_HEIGHT_W-1:0];
      csr_chan.valid <= 1'b0;
   endtask

   task automatic test_full_width_at_reset();
      // width stays at its reset value, height 0 acts as one row
      configure(1'b1, '0, '0);
      repeat (MAX_W - 1) send_pixel(any_pixel(), 1'b0);
      // an oversized width clamps to the full row, so one more pixel closes it
      configure(1'b0, 13'h1FFF, '0);
      send_pixel(any_pixel(), 1'b0);
      // narrow rows keep the drain short
      configure(1'b0, 13'd2, '0);
      drain_image(0);
   endtask

   task automatic test_corner_values();
      configure(1'b0, 13'd3, 13'd3);
      send_pixel('1, 1'b0);
      send_pixel('0, 1'b0);
      send_pixel(32'hAA55_AA55, 1'b0);
      send_pixel(32'h55AA_55AA, 1'b0);
      send_pixel('1, 1'b1);
      send_pixel('1, 1'b0);
      send_pixel('1, 1'b0);
      send_pixel('0, 1'b0);
      send_pixel(32'h80FF_017F, 1'b0);
      // real pixels in the drain positions must be masked
      drain_image(100);
   endtask

   task automatic test_single_column();
      configure(1'b0, 13'd0, 13'd3);
      send_image(0);
      drain_image(0);
   endtask

   task automatic test_extra_fillers();
      configure(1'b0, 13'd2, 13'd2);
      send_image(0);
      drain_image(0);
      repeat (3) send_pixel(any_pixel(), 1'b1);
      send_pixel(any_pixel(), 1'b0);
      drain_image(0);
   endtask

   task automatic test_tall_narrow();
      configure(1'b0, 13'd1, 13'd12);
      send_image(0);
      drain_image(0);
   endtask

   task automatic test_width_shrink_mid_image();
      configure(1'b0, 13'd6, 13'd5);
      repeat (15) send_pixel(any_pixel(), 1'b0);
      // column now beyond the new width, restarts at zero on the same row
      configure(1'b0, 13'h1802, 13'd5);
      repeat (6) send_pixel(any_pixel(), 1'b0);
      drain_image(0);
   endtask

   task automatic test_height_shrink_mid_image();
      configure(1'b0, 13'd2, 13'h1FFF);
      repeat (12) send_pixel(any_pixel(), 1'b0);
      // row now above height + 1, restarts at zero
      configure(1'b1, '0, 13'd3);
      repeat (6) send_pixel(any_pixel(), 1'b0);
      drain_image(0);
   endtask

   task automatic test_random_images();
      int unsigned start, w, h;
      bit          first;
      start = pixels_sent;
      first = 1'b1;
      while (pixels_sent - start < RANDOM_ITEMS) begin
         if (first || $urandom_range(2) == 0) begin
            drain_image(0);
            if ($urandom_range(9) == 0) w = $urandom_range(40, 11);
            else if ($urandom_range(19) == 0) w = 0;
            else w = $urandom_range(10, 1);
            h = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
            configure(1'b0, {2'($urandom_range(3)), CFG_WIDTH_W'(w)}, CSR_DATA_W'(h));
            first = 1'b0;
         end
         send_image(($urandom_range(3) == 0) ? 8 : 0);
         drain_image(($urandom_range(4) == 0) ? 50 : 0);
         if ($urandom_range(5) == 0)
            repeat ($urandom_range(3, 1)) send_pixel(any_pixel(), 1'b1);
      end
   endtask

   always @(posedge clock) begin : check_results
      blur_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_blurs.size() == 0) begin
            report_mismatch("response transaction with no blurred pixel expected");
         end else begin
            want = pending_blurs.pop_front();
            if (rsp_chan.out_red !== want.colour.red)
               report_mismatch($sformatf("pixel %0d red: got %0d, want %0d", checked_count,
                                         rsp_chan.out_red, want.colour.red));
            if (rsp_chan.out_green !== want.colour.green)
               report_mismatch($sformatf("pixel %0d green: got %0d, want %0d", checked_count,
                                         rsp_chan.out_green, want.colour.green));
            if (rsp_chan.out_blue !== want.colour.blue)
               report_mismatch($sformatf("pixel %0d blue: got %0d, want %0d", checked_count,
                                         rsp_chan.out_blue, want.colour.blue));
            if (rsp_chan.out_alpha !== want.colour.alpha)
               report_mismatch($sformatf("pixel %0d alpha: got %0d, want %0d", checked_count,
                                         rsp_chan.out_alpha, want.colour.alpha));
            if (rsp_chan.frame_end !== want.frame_end)
               report_mismatch($sformatf("pixel %0d frame_end: got %0b, want %0b",
                                         checked_count, rsp_chan.frame_end, want.frame_end));
         end
         checked_count++;
      end
      rsp_chan.ready <= steady || ($urandom_range(99) >= 12);
   end

   initial begin
      width_reg  = RESET_IMAGE_WIDTH;
      height_reg = RESET_IMAGE_HEIGHT;
      col_pos    = 0;
      row_pos    = 0;
      for (int i = 0; i < 9; i++) window_taps[i] = '0;
      for (int i = 0; i < MAX_W; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.in_red    <= '0;
      req_chan.in_green  <= '0;
      req_chan.in_blue   <= '0;
      req_chan.in_alpha  <= '0;
      req_chan.is_filler <= 1'b0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= CSR_IMAGE_WIDTH;
      csr_chan.data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_full_width_at_reset();
      test_corner_values();
      test_single_column();
      test_extra_fillers();
      test_width_shrink_mid_image();
      test_height_shrink_mid_image();
      test_tall_narrow();
      test_random_images();

      req_chan.valid <= 1'b0;
      while (pending_blurs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
